FILE: rtl/tdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_pkg: shared definitions for the trial division factorizer
// Widths, limits and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tdf_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int EXP_BITS       = 5;
  localparam int EXP_MAX        = 31;
  localparam int MAX_RESULTS    = 9;
  localparam int CNT_BITS       = $clog2(MAX_RESULTS + 1);
  localparam int FIRST_DIVISOR  = 2;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new request
    logic div_start;   // begin remainder / divisor
    logic div_step;    // one quotient bit
    logic take_quot;   // divisor divides: keep quotient, bump count
    logic next_div;    // move to the next trial divisor
    logic emit_fac;    // load a factor into the output register
    logic emit_rem;    // load the leftover prime into the output register
    logic emit_empty;  // load the empty result into the output register
  } tdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_small;    // incoming value below 2
    logic sq_gt;       // divisor squared above remainder
    logic div_last;    // final quotient bit this cycle
    logic rem_zero;    // division left nothing
    logic cnt_nz;      // current divisor divided at least once
    logic fac_last;    // factor being emitted closes the run
    logic out_free;    // output register can take a result
  } tdf_status_t;

endpackage : tdf_pkg
`default_nettype wire

FILE: rtl/trial_division_factorizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_factorizer: prime factorization by trial division
// Factors one value per request and returns its prime / exponent pairs in
// ascending order, the final one flagged last; values below 2 give a single
// empty result.
//
//   channel   direction  handshake            payload
//   in        into block in_valid / in_stall   value
//   out       from block out_valid / out_stall prime, exponent, empty_res, last
//
// each trial divisor costs one bit-serial division (one quotient bit a
// cycle), plus another division for every extra time it divides, and
// one emit step for each factor sent;
// a request takes about sqrt(largest cofactor) trials; one request is
// worked at a time
// reset clears the controller and the output valid; no clearing pass
// a stalled output holds the controller until the result register frees up
// ----------------------------------------------------------------------------
module trial_division_factorizer #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [VALUE_BITS-1:0]        value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [VALUE_BITS-1:0]        prime,
  output logic [tdf_pkg::EXP_BITS-1:0] exponent,
  output logic                         empty_res,
  output logic                         last
);
  import tdf_pkg::*;

  tdf_cmd_t    cmd;
  tdf_status_t status;

  tdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  tdf_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .prime     (prime),
    .exponent  (exponent),
    .empty_res (empty_res),
    .last      (last)
  );

endmodule : trial_division_factorizer
`default_nettype wire

FILE: rtl/tdf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_datapath: remainder, trial divisor and bit-serial divider
// Holds the value being factored, the divisor and its square, a restoring
// divider that yields one quotient bit per cycle, and the output register.
// ----------------------------------------------------------------------------
module tdf_datapath #(
  parameter int VALUE_BITS = tdf_pkg::VALUE_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  tdf_pkg::tdf_cmd_t            cmd,
  output tdf_pkg::tdf_status_t         status,
  input  wire  [VALUE_BITS-1:0]        value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [VALUE_BITS-1:0]        prime,
  output logic [tdf_pkg::EXP_BITS-1:0] exponent,
  output logic                         empty_res,
  output logic                         last
);
  import tdf_pkg::*;

  localparam int DIV_BITS  = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS   = VALUE_BITS + 1;
  localparam int STEP_BITS = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] remainder;
  logic [DIV_BITS-1:0]   trial_divisor;
  logic [SQ_BITS-1:0]    div_square;
  logic [EXP_BITS-1:0]   multiplicity;
  logic [CNT_BITS-1:0]   results_sent;

  // divider state: dividend shifts out on top, quotient shifts in below
  logic [VALUE_BITS-1:0] dvd;
  logic [DIV_BITS-1:0]   part_rem;
  logic [STEP_BITS-1:0]  step;

  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;
  logic                  trial_ge;
  logic                  out_free;

  assign trial    = {part_rem, dvd[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, trial_divisor};
  assign trial_ge = trial >= {1'b0, trial_divisor};
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    status.in_small = value < VALUE_BITS'(FIRST_DIVISOR);
    status.sq_gt    = div_square > {1'b0, remainder};
    status.div_last = step == '0;
    status.rem_zero = part_rem == '0;
    status.cnt_nz   = multiplicity != '0;
    status.fac_last = (remainder == VALUE_BITS'(1)) ||
                      (results_sent == CNT_BITS'(MAX_RESULTS - 1));
    status.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remainder     <= value;
      trial_divisor <= DIV_BITS'(FIRST_DIVISOR);
      div_square    <= SQ_BITS'(FIRST_DIVISOR * FIRST_DIVISOR);
      multiplicity  <= '0;
      results_sent  <= '0;
    end else begin
      if (cmd.take_quot) begin
        remainder <= dvd;
        if (multiplicity != EXP_BITS'(EXP_MAX)) begin
          multiplicity <= multiplicity + EXP_BITS'(1);
        end
      end
      if (cmd.next_div) begin
        trial_divisor <= trial_divisor + DIV_BITS'(1);
        // (d+1)^2 = d^2 + 2d + 1
        div_square    <= div_square + SQ_BITS'({trial_divisor, 1'b1});
        multiplicity  <= '0;
      end
      if (cmd.emit_fac) begin
        results_sent <= results_sent + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd      <= remainder;
      part_rem <= '0;
      step     <= STEP_BITS'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      dvd      <= {dvd[VALUE_BITS-2:0], trial_ge};
      part_rem <= trial_ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      step     <= step - STEP_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_fac || cmd.emit_rem || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fac) begin
      prime     <= VALUE_BITS'(trial_divisor);
      exponent  <= multiplicity;
      empty_res <= 1'b0;
      last      <= status.fac_last;
    end else if (cmd.emit_rem) begin
      prime     <= remainder;
      exponent  <= EXP_BITS'(1);
      empty_res <= 1'b0;
      last      <= 1'b1;
    end else if (cmd.emit_empty) begin
      prime     <= '0;
      exponent  <= '0;
      empty_res <= 1'b1;
      last      <= 1'b1;
    end
  end

endmodule : tdf_datapath
`default_nettype wire

FILE: rtl/tdf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdf_ctrl: sequencing of the trial division loop
// Walks divisors upward, runs one bit-serial division per trial, divides a
// divisor out while it fits and hands each factor to the output register.
// ----------------------------------------------------------------------------
module tdf_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  output tdf_pkg::tdf_cmd_t     cmd,
  input  tdf_pkg::tdf_status_t  status
);
  import tdf_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE       = 8'b0000_0001,
    ST_CHECK      = 8'b0000_0010,
    ST_START      = 8'b0000_0100,
    ST_DIV        = 8'b0000_1000,
    ST_TEST       = 8'b0001_0000,
    ST_EMIT_FAC   = 8'b0010_0000,
    ST_EMIT_REM   = 8'b0100_0000,
    ST_EMIT_EMPTY = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_small ? ST_EMIT_EMPTY : ST_CHECK;
        end
      end
      ST_CHECK: begin
        // nothing left below the square root: what remains is prime
        state_next = status.sq_gt ? ST_EMIT_REM : ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status.rem_zero) begin
          cmd.take_quot = 1'b1;
          state_next    = ST_START;
        end else if (status.cnt_nz) begin
          state_next = ST_EMIT_FAC;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = ST_CHECK;
        end
      end
      ST_EMIT_FAC: begin
        if (status.out_free) begin
          cmd.emit_fac = 1'b1;
          if (status.fac_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next_div = 1'b1;
            state_next   = ST_CHECK;
          end
        end
      end
      ST_EMIT_REM: begin
        if (status.out_free) begin
          cmd.emit_rem = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : tdf_ctrl
`default_nettype wire

FILE: dv/tb_trial_division_factorizer.sv
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer: self-checking bench for the factorizer
// A directed table covers values below 2, small primes, the largest exponent,
// the most distinct primes and the wide bit patterns. Random products of small
// factors follow. Untyped rows are factored by a local trial-division
// predictor, and each prime / exponent result is checked in order.
// Both channels idle in random bursts, and the run ends with no idling.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer;
  import tdf_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam longint unsigned VMAX = (64'd1 << VB) - 1;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int DIRECTED_ROWS = 16;
  localparam int RANDOM_ROWS = 100;
  localparam int CALM_ROWS = 20;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [VB-1:0]       prime;
    logic [EXP_BITS-1:0] exponent;
    logic                empty_res;
    logic                last;
  } factor_t;

  // typed rows carry a single hand-written result, the others go to the predictor
  typedef struct packed {
    logic [VB-1:0]       value;
    logic                typed;
    logic [VB-1:0]       prime;
    logic [EXP_BITS-1:0] exponent;
  } request_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VB-1:0]       value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [VB-1:0]       prime;
  logic [EXP_BITS-1:0] exponent;
  logic                empty_res;
  logic                last;

  request_t requests_sent[$];
  factor_t  factors_due[$];

  // predictor state, left by the last request
  logic [VB-1:0]       rem_left = '0;
  logic [15:0]         div_left = 16'd2;
  logic [EXP_BITS-1:0] mult_left = '0;

  int unsigned cycles = 0;
  int          mismatches = 0;
  int          n_requests = 0;
  int          n_results = 0;
  int          n_empty = 0;
  int          run_len = 0;
  int          longest_run = 0;
  int          top_exponent = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  request_t directed_tbl [DIRECTED_ROWS] = '{
    '{31'd0,          1'b1, 31'd0, 5'd0},
    '{31'd1,          1'b1, 31'd0, 5'd0},
    '{31'd2,          1'b1, 31'd2, 5'd1},
    '{31'd3,          1'b1, 31'd3, 5'd1},
    '{31'd1073741824, 1'b1, 31'd2, 5'd30},
    '{31'd2147483646, 1'b0, 31'd0, 5'd0},
    '{31'd4,          1'b0, 31'd0, 5'd0},
    '{31'd6,          1'b0, 31'd0, 5'd0},
    '{31'd223092870,  1'b0, 31'd0, 5'd0},
    '{31'd1162261467, 1'b0, 31'd0, 5'd0},
    '{31'd65521,      1'b0, 31'd0, 5'd0},
    '{31'd63001,      1'b0, 31'd0, 5'd0},
    '{31'd1000003,    1'b0, 31'd0, 5'd0},
    '{31'd1431655765, 1'b0, 31'd0, 5'd0},
    '{31'd720720,     1'b0, 31'd0, 5'd0},
    '{31'd30030,      1'b0, 31'd0, 5'd0}
  };

  trial_division_factorizer #(.VALUE_BITS(VB)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .prime     (prime),
    .exponent  (exponent),
    .empty_res (empty_res),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, factors_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input longint unsigned got,
                        input longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // trial division: divide each divisor out fully, leftover above 1 is prime
  function automatic void factor_value(input logic [VB-1:0] v);
    longint unsigned rem;
    longint unsigned d;
    longint unsigned cnt;
    int              n;
    factor_t         run [MAX_RESULTS];
    factor_t         f;
    rem = 64'(v);
    d = 2;
    n = 0;
    if (rem < 2) begin
      rem_left = rem[VB-1:0];
      div_left = 16'd2;
      mult_left = '0;
      f.prime = '0;
      f.exponent = '0;
      f.empty_res = 1'b1;
      f.last = 1'b1;
      factors_due.push_back(f);
      return;
    end
    while (d * d <= rem) begin
      cnt = 0;
      while (rem % d == 0) begin
        rem = rem / d;
        if (cnt < EXP_MAX) cnt++;
      end
      mult_left = cnt[EXP_BITS-1:0];
      if (cnt > 0 && n < MAX_RESULTS) begin
        run[n].prime = d[VB-1:0];
        run[n].exponent = cnt[EXP_BITS-1:0];
        n++;
      end
      d++;
    end
    if (rem > 1 && n < MAX_RESULTS) begin
      run[n].prime = rem[VB-1:0];
      run[n].exponent = EXP_BITS'(1);
      n++;
      rem = 1;
    end
    rem_left = rem[VB-1:0];
    div_left = d[15:0];
    for (int i = 0; i < n; i++) begin
      f = run[i];
      f.empty_res = 1'b0;
      f.last = (i == n - 1);
      factors_due.push_back(f);
    end
  endfunction

  // mostly products of small factors over a bounded cofactor so runs stay short
  function automatic logic [VB-1:0] draw_value();
    int              kind;
    longint unsigned acc;
    longint unsigned f;
    kind = $urandom_range(0, 19);
    if (kind == 0) return VB'($urandom_range(0, 3));
    if (kind == 1) return VB'($urandom_range(0, 1 << 18));
    if (kind <= 4) begin
      acc = 64'($urandom_range(2, 40));
      f = acc;
      repeat ($urandom_range(1, 30)) begin
        if (acc * f <= VMAX) acc = acc * f;
      end
      return acc[VB-1:0];
    end
    acc = 64'($urandom_range(1, 8191));
    repeat ($urandom_range(0, 14)) begin
      f = 64'($urandom_range(2, 64));
      if (acc * f <= VMAX) acc = acc * f;
    end
    return acc[VB-1:0];
  endfunction

  task automatic send_request(input request_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    requests_sent.push_back(r);
    in_valid <= 1'b1;
    value <= r.value;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    @(posedge clk);
    while (requests_sent.size() != 0 || factors_due.size() != 0) @(posedge clk);
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : monitor
    request_t r;
    factor_t  want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        r = requests_sent.pop_front();
        n_requests++;
        if (r.typed) begin
          want.prime = r.prime;
          want.exponent = r.exponent;
          want.empty_res = (r.prime == 0);
          want.last = 1'b1;
          factors_due.push_back(want);
        end else begin
          factor_value(r.value);
        end
      end
      if (out_valid && !out_stall) begin
        n_results++;
        run_len++;
        if (empty_res) n_empty++;
        if (int'(exponent) > top_exponent) top_exponent = int'(exponent);
        if (last) begin
          if (run_len > longest_run) longest_run = run_len;
          run_len = 0;
        end
        if (factors_due.size() == 0) begin
          report("result with nothing pending, prime", prime, 0);
        end else begin
          want = factors_due.pop_front();
          if (prime !== want.prime) report("prime", prime, want.prime);
          if (exponent !== want.exponent) report("exponent", exponent, want.exponent);
          if (empty_res !== want.empty_res) report("empty_res", empty_res, want.empty_res);
          if (last !== want.last) report("last", last, want.last);
        end
      end
    end
  end

  initial begin : stimulus
    request_t row;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_request(directed_tbl[i]);
    // hold off until the directed results have all drained
    in_valid <= 1'b0;
    wait_for_results();

    for (int i = 0; i < RANDOM_ROWS; i++) begin
      if (i == RANDOM_ROWS - CALM_ROWS) calm = 1'b1;
      row.value = draw_value();
      row.typed = 1'b0;
      row.prime = '0;
      row.exponent = '0;
      send_request(row);
    end
    in_valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed) giving %0d results, %0d of them empty",
             n_requests, DIRECTED_ROWS, n_results, n_empty);
    $display("longest run %0d results, highest exponent %0d, %0d mismatches in %0d cycles",
             longest_run, top_exponent, mismatches, cycles);
    if (mismatches == 0 && factors_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
